>>> rtl/sspd_pkg.sv
// package: shared types, constants and tables for the sphere point evaluator
`timescale 1ns / 1ps
package sspd_pkg;

    localparam int ANGLE_BITS_DEF = 16;
    localparam int COORD_BITS_DEF = 16;
    localparam int CORDIC_STEPS   = 16;
    localparam logic signed [31:0] CORDIC_GAIN = 32'sd652032874;

    localparam logic [2:0] MODE_POINT  = 3'd0;
    localparam logic [2:0] MODE_FIRST  = 3'd1;
    localparam logic [2:0] MODE_SECOND = 3'd2;
    localparam logic [2:0] MODE_THIRD  = 3'd3;
    localparam logic [2:0] MODE_CHOSEN = 3'd4;

    localparam logic [3:0] KIND_CHOSEN = 4'd10;

    localparam logic [2:0] REG_CENTRE = 3'd0;
    localparam logic [2:0] REG_XAXIS  = 3'd1;
    localparam logic [2:0] REG_YAXIS  = 3'd2;
    localparam logic [2:0] REG_ZAXIS  = 3'd3;
    localparam logic [2:0] REG_RADIUS = 3'd4;
    localparam logic [2:0] REG_MODE   = 3'd5;
    localparam logic [2:0] REG_ORDU   = 3'd6;
    localparam logic [2:0] REG_ORDV   = 3'd7;

    // coefficient selectors
    typedef enum logic [2:0] {
        SEL_ZERO = 3'd0,
        SEL_RC   = 3'd1,
        SEL_NRC  = 3'd2,
        SEL_RS   = 3'd3,
        SEL_NRS  = 3'd4
    } sel_t;

    typedef struct packed {
        sel_t a_sel;
        logic use_dd;
        sel_t b_sel;
        logic with_c;
    } spec_t;

    typedef struct packed {
        logic signed [15:0] cu;
        logic signed [15:0] su;
        logic signed [15:0] cv;
        logic signed [15:0] sv;
    } trig_t;

    function automatic logic [31:0] atan_val(input int i);
        logic [31:0] r;
        unique case (i)
            0:  r = 32'd536870912;
            1:  r = 32'd316933406;
            2:  r = 32'd167458907;
            3:  r = 32'd85004756;
            4:  r = 32'd42667331;
            5:  r = 32'd21354465;
            6:  r = 32'd10679838;
            7:  r = 32'd5340245;
            8:  r = 32'd2670163;
            9:  r = 32'd1335087;
            10: r = 32'd667544;
            11: r = 32'd333772;
            12: r = 32'd166886;
            13: r = 32'd83443;
            14: r = 32'd41722;
            default: r = 32'd20861;
        endcase
        return r;
    endfunction

    function automatic spec_t spec_of(input logic [3:0] k);
        spec_t s;
        unique case (k)
            4'd0:    s = '{SEL_RC,  1'b0, SEL_RS,  1'b1};
            4'd1:    s = '{SEL_RC,  1'b1, SEL_ZERO, 1'b0};
            4'd2:    s = '{SEL_NRS, 1'b0, SEL_RC,  1'b0};
            4'd3:    s = '{SEL_NRC, 1'b0, SEL_ZERO, 1'b0};
            4'd4:    s = '{SEL_NRC, 1'b0, SEL_NRS, 1'b0};
            4'd5:    s = '{SEL_NRS, 1'b1, SEL_ZERO, 1'b0};
            4'd6:    s = '{SEL_NRC, 1'b1, SEL_ZERO, 1'b0};
            4'd7:    s = '{SEL_RS,  1'b0, SEL_NRC, 1'b0};
            4'd8:    s = '{SEL_RS,  1'b0, SEL_ZERO, 1'b0};
            default: s = '{SEL_NRC, 1'b1, SEL_ZERO, 1'b0};
        endcase
        return s;
    endfunction

    function automatic logic [3:0] mode_count(input logic [2:0] m);
        logic [3:0] r;
        unique case (m)
            MODE_POINT:  r = 4'd1;
            MODE_FIRST:  r = 4'd3;
            MODE_SECOND: r = 4'd6;
            MODE_THIRD:  r = 4'd10;
            default:     r = 4'd1;
        endcase
        return r;
    endfunction

endpackage

>>> rtl/sphere_surface_point_derivatives.sv
// top level: sphere point and derivative evaluator with apb register port
`timescale 1ns / 1ps
// Each accepted (u,v) beat runs through a fixed pipeline: angle cordic (6 register stages),
// direction products (2 stages), a sequencer register that emits one vector per cycle unless
// the output stalls, then the combine pipeline (3 stages, the last of which drives the
// outputs). Modes point and chosen derivative take one input beat per cycle when the output
// does not stall; first, second and third derivative modes give 3, 6 and 10 output vectors
// per input beat. Chosen derivative with both orders zero and modes 5 to 7 give no output.
module sphere_surface_point_derivatives
    import sspd_pkg::*;
#(
    parameter int ANGLE_BITS = ANGLE_BITS_DEF,
    parameter int COORD_BITS = COORD_BITS_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [5:0]          paddr,
    input  logic [63:0]         pwdata,
    output logic [63:0]         prdata,
    output logic                pready,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [15:0]         u_angle,
    input  logic [15:0]         v_angle,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [3:0]          vector_kind,
    output logic signed [31:0]  out_x,
    output logic signed [31:0]  out_y,
    output logic signed [31:0]  out_z,
    output logic                last
);

    localparam int LANE = (COORD_BITS < 16) ? COORD_BITS : 16;
    localparam int FRONT = 8;
    localparam int BACK = 2;

    logic [47:0] cen_reg, xa_reg, ya_reg, za_reg;
    logic [15:0] rad_reg;
    logic [2:0]  mode_reg;
    logic [3:0]  ordu_reg, ordv_reg;

    assign pready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cen_reg  <= '0;
            xa_reg   <= 48'd16384;
            ya_reg   <= 48'd1073741824;
            za_reg   <= 48'd70368744177664;
            rad_reg  <= 16'd1;
            mode_reg <= MODE_POINT;
            ordu_reg <= 4'd1;
            ordv_reg <= 4'd0;
        end
        else if (psel && penable && pwrite)
        begin
            unique case (paddr[5:3])
                REG_CENTRE: cen_reg  <= pwdata[47:0];
                REG_XAXIS:  xa_reg   <= pwdata[47:0];
                REG_YAXIS:  ya_reg   <= pwdata[47:0];
                REG_ZAXIS:  za_reg   <= pwdata[47:0];
                REG_RADIUS: rad_reg  <= pwdata[15:0];
                REG_MODE:   mode_reg <= pwdata[2:0];
                REG_ORDU:   ordu_reg <= pwdata[3:0];
                default:    ordv_reg <= pwdata[3:0];
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[5:3])
            REG_CENTRE: prdata = {16'd0, cen_reg};
            REG_XAXIS:  prdata = {16'd0, xa_reg};
            REG_YAXIS:  prdata = {16'd0, ya_reg};
            REG_ZAXIS:  prdata = {16'd0, za_reg};
            REG_RADIUS: prdata = {48'd0, rad_reg};
            REG_MODE:   prdata = {61'd0, mode_reg};
            REG_ORDU:   prdata = {60'd0, ordu_reg};
            default:    prdata = {60'd0, ordv_reg};
        endcase
    end

    // sequencer: holds one item's products and counts out its vectors
    logic       seq_busy_reg;
    logic [3:0] seq_idx_reg;
    logic [3:0] seq_cnt;
    logic       back_adv;
    logic       seq_take;
    logic       front_adv;
    logic [FRONT-1:0] fv_reg;

    // output register and back pipe
    logic [BACK-1:0] bv_reg;
    logic            ov_reg;
    assign back_adv = !ov_reg || !out_stall;

    logic seq_done;
    assign seq_cnt  = (mode_reg == MODE_CHOSEN) ? 4'd1 : mode_count(mode_reg);
    assign seq_done = seq_busy_reg && (seq_idx_reg == seq_cnt - 4'd1) && back_adv;
    assign seq_take = !seq_busy_reg || seq_done;
    assign front_adv = !fv_reg[FRONT-1] || seq_take;
    assign in_stall = !front_adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fv_reg <= '0;
        else if (front_adv)
            fv_reg <= {fv_reg[FRONT-2:0], in_valid};
    end

    logic signed [15:0] cu, su, cv, sv;
    sspd_cordic #(.ANGLE_BITS(ANGLE_BITS)) u_cu (
        .clk(clk), .rst_n(rst_n), .adv(front_adv),
        .ang(ANGLE_BITS'(u_angle)), .cos_q(cu), .sin_q(su));
    sspd_cordic #(.ANGLE_BITS(ANGLE_BITS)) u_cv (
        .clk(clk), .rst_n(rst_n), .adv(front_adv),
        .ang(ANGLE_BITS'(v_angle)), .cos_q(cv), .sin_q(sv));

    // product stage: cordic output at fv[5], products at fv[6], rounded at fv[7]
    logic signed [31:0] pc_reg [3], ps_reg [3], pdc_reg [3], pds_reg [3];
    logic signed [32:0] rc_reg, rs_reg;
    logic signed [17:0] du_reg [3], dd_reg [3];
    logic signed [32:0] rc2_reg, rs2_reg;

    always_ff @(posedge clk)
    begin
        if (front_adv)
        begin
            for (int j = 0; j < 3; j++)
            begin
                pc_reg[j]  <= cu * $signed(xa_reg[16*j +: 16]);
                ps_reg[j]  <= su * $signed(ya_reg[16*j +: 16]);
                pds_reg[j] <= su * $signed(xa_reg[16*j +: 16]);
                pdc_reg[j] <= cu * $signed(ya_reg[16*j +: 16]);
            end
            rc_reg <= $signed({1'b0, 16'(rad_reg[LANE-1:0])}) * cv;
            rs_reg <= $signed({1'b0, 16'(rad_reg[LANE-1:0])}) * sv;
            for (int j = 0; j < 3; j++)
            begin
                du_reg[j] <= 18'((34'(pc_reg[j]) + 34'(ps_reg[j]) + 34'sd8192) >>> 14);
                dd_reg[j] <= 18'((34'(pdc_reg[j]) - 34'(pds_reg[j]) + 34'sd8192) >>> 14);
            end
            rc2_reg <= rc_reg;
            rs2_reg <= rs_reg;
        end
    end

    logic signed [17:0] sdu_reg [3], sdd_reg [3];
    logic signed [32:0] src_reg, srs_reg;

    logic item_none;
    assign item_none = (mode_reg > MODE_CHOSEN) ||
                       (mode_reg == MODE_CHOSEN && ordu_reg == 4'd0 && ordv_reg == 4'd0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_busy_reg <= 1'b0;
            seq_idx_reg  <= '0;
        end
        else if (seq_take)
        begin
            seq_busy_reg <= fv_reg[FRONT-1] && !item_none;
            seq_idx_reg  <= '0;
        end
        else if (back_adv)
            seq_idx_reg <= seq_idx_reg + 4'd1;
    end

    always_ff @(posedge clk)
    begin
        if (seq_take)
        begin
            sdu_reg <= du_reg;
            sdd_reg <= dd_reg;
            src_reg <= rc2_reg;
            srs_reg <= rs2_reg;
        end
    end

    function automatic logic signed [32:0] pick(input sel_t s, input logic signed [32:0] rc,
                                                input logic signed [32:0] rs);
        logic signed [32:0] r;
        unique case (s)
            SEL_RC:  r = rc;
            SEL_NRC: r = -rc;
            SEL_RS:  r = rs;
            SEL_NRS: r = -rs;
            default: r = '0;
        endcase
        return r;
    endfunction

    logic signed [32:0] a_c, b_c, cxy, cz;
    logic               dd_c, wc_c;
    logic [3:0]         kind_c;
    spec_t              sp;
    always_comb
    begin
        sp = spec_of(seq_idx_reg);
        unique case (ordv_reg[1:0])
            2'd0:    begin cxy = src_reg;  cz = srs_reg;  end
            2'd1:    begin cxy = -srs_reg; cz = src_reg;  end
            2'd2:    begin cxy = -src_reg; cz = -srs_reg; end
            default: begin cxy = srs_reg;  cz = -src_reg; end
        endcase
        if (mode_reg == MODE_CHOSEN)
        begin
            a_c    = ordu_reg[1] ? -cxy : cxy;
            b_c    = (ordu_reg == 4'd0) ? cz : '0;
            dd_c   = ordu_reg[0];
            wc_c   = 1'b0;
            kind_c = KIND_CHOSEN;
        end
        else
        begin
            a_c    = pick(sp.a_sel, src_reg, srs_reg);
            b_c    = pick(sp.b_sel, src_reg, srs_reg);
            dd_c   = sp.use_dd;
            wc_c   = sp.with_c;
            kind_c = seq_idx_reg;
        end
    end

    logic [3:0] bk_reg [BACK];
    logic       bl_reg [BACK];
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bv_reg <= '0;
            ov_reg <= 1'b0;
        end
        else if (back_adv)
        begin
            bv_reg <= {bv_reg[BACK-2:0], seq_busy_reg};
            ov_reg <= bv_reg[BACK-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (back_adv)
        begin
            bk_reg[0] <= kind_c;
            bl_reg[0] <= (seq_idx_reg == seq_cnt - 4'd1);
            for (int i = 1; i < BACK; i++)
            begin
                bk_reg[i] <= bk_reg[i-1];
                bl_reg[i] <= bl_reg[i-1];
            end
        end
    end

    // two register stages in the combine unit, a third holds its inputs
    logic signed [32:0] a_reg, b_reg;
    logic signed [17:0] d_reg [3];
    logic               wc_reg;
    always_ff @(posedge clk)
    begin
        if (back_adv)
        begin
            a_reg  <= a_c;
            b_reg  <= b_c;
            wc_reg <= wc_c;
            for (int j = 0; j < 3; j++)
                d_reg[j] <= dd_c ? sdd_reg[j] : sdu_reg[j];
        end
    end

    logic signed [31:0] res [3];
    for (genvar j = 0; j < 3; j++)
    begin : g_lane
        logic signed [15:0] cen_l;
        assign cen_l = 16'($signed(cen_reg[16*j +: LANE]));
        sspd_vec u_vec (
            .clk(clk), .adv(back_adv), .a(a_reg), .b(b_reg), .dir(d_reg[j]),
            .zc($signed(za_reg[16*j +: 16])), .cen(cen_l), .with_c(wc_reg), .res(res[j]));
    end

    logic [3:0] ok_reg;
    logic       ol_reg;
    always_ff @(posedge clk)
    begin
        if (back_adv)
        begin
            ok_reg <= bk_reg[BACK-1];
            ol_reg <= bl_reg[BACK-1];
        end
    end

    assign out_valid   = ov_reg;
    assign vector_kind = ok_reg;
    assign out_x       = res[0];
    assign out_y       = res[1];
    assign out_z       = res[2];
    assign last        = ol_reg;

    logic unused_s;
    assign unused_s = ^paddr[2:0] ^ ^pwdata[63:48];

    a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
        seq_busy_reg |-> seq_idx_reg < seq_cnt)
        else $error("sequence index past vector count");
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(vector_kind) && $stable(last))
        else $error("output changed under stall");
    a_take_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !seq_busy_reg |-> seq_take)
        else $error("idle sequencer refused an item");

endmodule

>>> rtl/sspd_cordic.sv
// module: pipelined rotation cordic giving cos and sin of a turn angle in q1.14
`timescale 1ns / 1ps
module sspd_cordic
    import sspd_pkg::*;
#(
    parameter int ANGLE_BITS = ANGLE_BITS_DEF
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    adv,
    input  logic [ANGLE_BITS-1:0]   ang,
    output logic signed [15:0]      cos_q,
    output logic signed [15:0]      sin_q
);

    localparam int NS = CORDIC_STEPS;
    localparam int NG = NS / 4;

    logic signed [33:0] x_reg [NG+1];
    logic signed [33:0] y_reg [NG+1];
    logic signed [33:0] z_reg [NG+1];
    logic [1:0]         q_reg [NG+1];
    logic signed [33:0] x_next [NG];
    logic signed [33:0] y_next [NG];
    logic signed [33:0] z_next [NG];
    logic signed [15:0] cos_reg, sin_reg;

    logic [31:0] a32;
    assign a32 = 32'(ang) << (32 - ANGLE_BITS);

    // four rotations per register stage
    for (genvar g = 0; g < NG; g++)
    begin : g_stage
        logic signed [33:0] xs [5];
        logic signed [33:0] ys [5];
        logic signed [33:0] zs [5];
        always_comb
        begin
            xs[0] = x_reg[g];
            ys[0] = y_reg[g];
            zs[0] = z_reg[g];
            for (int k = 0; k < 4; k++)
            begin
                if (!zs[k][33])
                begin
                    xs[k+1] = xs[k] - (ys[k] >>> (4*g + k));
                    ys[k+1] = ys[k] + (xs[k] >>> (4*g + k));
                    zs[k+1] = zs[k] - $signed({2'b0, atan_val(4*g + k)});
                end
                else
                begin
                    xs[k+1] = xs[k] + (ys[k] >>> (4*g + k));
                    ys[k+1] = ys[k] - (xs[k] >>> (4*g + k));
                    zs[k+1] = zs[k] + $signed({2'b0, atan_val(4*g + k)});
                end
            end
        end
        assign x_next[g] = xs[4];
        assign y_next[g] = ys[4];
        assign z_next[g] = zs[4];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            x_reg[0] <= 34'(CORDIC_GAIN);
            y_reg[0] <= '0;
            z_reg[0] <= {4'b0, a32[29:0]};
            q_reg[0] <= a32[31:30];
            for (int i = 0; i < NG; i++)
            begin
                x_reg[i+1] <= x_next[i];
                y_reg[i+1] <= y_next[i];
                z_reg[i+1] <= z_next[i];
                q_reg[i+1] <= q_reg[i];
            end
        end
    end

    logic signed [33:0] xr, yr;
    logic signed [15:0] cx, cy;
    always_comb
    begin
        xr = (x_reg[NG] + 34'sd32768) >>> 16;
        yr = (y_reg[NG] + 34'sd32768) >>> 16;
        cx = xr[15:0];
        cy = yr[15:0];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            unique case (q_reg[NG])
                2'd0:    begin cos_reg <= cx;  sin_reg <= cy;  end
                2'd1:    begin cos_reg <= -cy; sin_reg <= cx;  end
                2'd2:    begin cos_reg <= -cx; sin_reg <= -cy; end
                default: begin cos_reg <= cy;  sin_reg <= -cx; end
            endcase
        end
    end

    assign cos_q = cos_reg;
    assign sin_q = sin_reg;

    logic unused_rst;
    assign unused_rst = rst_n;

endmodule

>>> rtl/sspd_vec.sv
// module: per-vector combine a*v + b*z, rounding, centre offset and saturation
`timescale 1ns / 1ps
module sspd_vec
    import sspd_pkg::*;
(
    input  logic                clk,
    input  logic                adv,
    input  logic signed [32:0]  a,
    input  logic signed [32:0]  b,
    input  logic signed [17:0]  dir,
    input  logic signed [15:0]  zc,
    input  logic signed [15:0]  cen,
    input  logic                with_c,
    output logic signed [31:0]  res
);

    logic signed [51:0] pa_reg, pb_reg;
    logic signed [15:0] cen_reg;
    logic               wc_reg;
    logic signed [31:0] res_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pa_reg  <= 52'(a) * 52'(dir);
            pb_reg  <= 52'(b) * 52'(zc);
            cen_reg <= cen;
            wc_reg  <= with_c;
        end
    end

    logic signed [53:0] s;
    logic signed [53:0] v;
    always_comb
    begin
        s = (54'(pa_reg) + 54'(pb_reg) + 54'sd32768) >>> 16;
        v = wc_reg ? s + (54'(cen_reg) <<< 12) : s;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            if (v > 54'sd2147483647)
                res_reg <= 32'sh7fffffff;
            else if (v < -54'sd2147483648)
                res_reg <= 32'sh80000000;
            else
                res_reg <= v[31:0];
        end
    end

    assign res = res_reg;

endmodule
